/* rtl/core/transposition_table_store_probe_top_macros.svh */
// assertion macros used by the transposition table checker
`ifndef TRANSPOSITION_TABLE_STORE_PROBE_TOP_MACROS_SVH
`define TRANSPOSITION_TABLE_STORE_PROBE_TOP_MACROS_SVH

// same-cycle implication
`define TTSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ttsp_pkg.sv */
// shared types, constants and helpers of the transposition table
package ttsp_pkg;

   localparam int INDEX_BITS = 16;
   localparam int MOVE_BITS  = 16;

   localparam int KEY_BITS    = 64;
   localparam int FIELD_BITS  = 16;
   localparam int BOUND_BITS  = 2;
   localparam int DEPTH_BITS  = 8;
   localparam int KIND_BITS   = 2;
   localparam int CFG_BITS    = 17;
   localparam int EPOCH_BITS  = 8;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 17'h10000;

   localparam logic [KIND_BITS-1:0]  KIND_STORE  = 2'd0;
   localparam logic [KIND_BITS-1:0]  KIND_PROBE  = 2'd1;
   localparam logic [KIND_BITS-1:0]  KIND_CLEAR  = 2'd2;
   localparam logic [BOUND_BITS-1:0] BOUND_EXACT = 2'd0;

   localparam int REQ_FIELD_BITS = KEY_BITS + 2 * FIELD_BITS + BOUND_BITS + DEPTH_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * FIELD_BITS + BOUND_BITS + DEPTH_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS  = 2;

   localparam int RSP_HIT_BIT     = 0;
   localparam int RSP_WRITTEN_BIT = 1;

   typedef struct packed {
      logic [REQ_DATA_BITS-REQ_FIELD_BITS-1:0] pad;
      logic [DEPTH_BITS-1:0]                   depth;
      logic [BOUND_BITS-1:0]                   bound;
      logic [FIELD_BITS-1:0]                   score;
      logic [FIELD_BITS-1:0]                   move;
      logic [KEY_BITS-1:0]                     key;
   } req_data_type;

   typedef struct packed {
      logic [RSP_DATA_BITS-RSP_FIELD_BITS-1:0] pad;
      logic [DEPTH_BITS-1:0]                   depth;
      logic [BOUND_BITS-1:0]                   bound;
      logic [FIELD_BITS-1:0]                   score;
      logic [FIELD_BITS-1:0]                   move;
   } rsp_data_type;

   typedef struct packed {
      logic written;
      logic hit;
   } rsp_user_type;

   typedef struct packed {
      logic                   valid;
      logic [EPOCH_BITS-1:0]  epoch;
      logic [KEY_BITS-1:0]    key;
      logic [MOVE_BITS-1:0]   move;
      logic [FIELD_BITS-1:0]  score;
      logic [BOUND_BITS-1:0]  bound;
      logic [DEPTH_BITS-1:0]  depth;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   typedef struct packed {
      logic                  rd_en;
      logic [INDEX_BITS-1:0] rd_addr;
      logic                  wr_en;
      logic [INDEX_BITS-1:0] wr_addr;
      slot_type              wr_word;
   } mem_req_type;

   function automatic logic [MOVE_BITS-1:0] move_to_slot(input logic [FIELD_BITS-1:0] mv);
      logic [MOVE_BITS+FIELD_BITS-1:0] wide;
      wide = {{MOVE_BITS{1'b0}}, mv};
      return wide[MOVE_BITS-1:0];
   endfunction

   function automatic logic [FIELD_BITS-1:0] move_from_slot(input logic [MOVE_BITS-1:0] mv);
      logic [MOVE_BITS+FIELD_BITS-1:0] wide;
      wide = {{FIELD_BITS{1'b0}}, mv};
      return wide[FIELD_BITS-1:0];
   endfunction

endpackage

/* rtl/core/transposition_table_store_probe_top.sv */
// top level of the direct-mapped transposition table
// a request passes the s1 register and the response register; same-slot back-to-back uses write forwarding
// throughput: one request per cycle while no sweep runs and no result stalls
// reset: a clearing pass over all 2**INDEX_BITS slots runs before the first request
// every 2**(EPOCH_BITS-1) table wipes a stale-entry scan holds off requests until it has swept every slot
module transposition_table_store_probe_top
   import ttsp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [CFG_BITS-1:0]      csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // position_key, best_move, eval_score, bound_kind, search_depth, zero pad
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // kind
   input  logic [KIND_BITS-1:0]     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // found_move, found_score, found_bound, found_depth, zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // hit, written
   output logic [RSP_USER_BITS-1:0] rsp_tuser
);

   req_data_type          req_fields;
   logic                  accept;
   logic                  s1_advance;

   logic                  s1_valid_ff;
   logic [KIND_BITS-1:0]  s1_kind_ff;
   req_data_type          s1_fields_ff;
   logic [INDEX_BITS-1:0] s1_idx;

   logic                  fwd_valid_ff;
   logic [INDEX_BITS-1:0] fwd_idx_ff;
   slot_type              fwd_word_ff;

   logic [EPOCH_BITS-1:0] epoch_ff;
   logic [EPOCH_BITS-1:0] epoch_in;
   logic [CFG_BITS-1:0]   count_ff;
   logic [CFG_BITS-1:0]   count_in;
   logic [CFG_BITS-1:0]   max_ff;

   logic                  rsp_valid_ff;
   rsp_data_type          rsp_data_ff;
   rsp_data_type          rsp_data_in;
   rsp_user_type          rsp_user_ff;
   rsp_user_type          rsp_user_in;

   slot_type              rd_word;
   slot_type              entry;
   slot_type              new_word;
   logic                  live;
   logic                  key_eq;
   logic                  full;
   logic                  is_exact;
   logic                  do_write;
   logic                  wipe;
   logic                  grow;
   logic                  hit;
   logic                  pipe_wr_en;
   logic                  sweep_start;

   logic                  sweep_busy;
   mem_req_type           sweep_req;

   logic                  ram_wr_en;
   logic [INDEX_BITS-1:0] ram_wr_addr;
   slot_type              ram_wr_word;
   logic                  ram_rd_en;
   logic [INDEX_BITS-1:0] ram_rd_addr;
   logic [SLOT_BITS-1:0]  ram_rd_data;

   assign req_fields = req_data_type'(req_tdata);
   assign s1_idx     = s1_fields_ff.key[INDEX_BITS-1:0];
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !sweep_busy && (!s1_valid_ff || s1_advance);
   assign accept     = req_tvalid && req_tready;

   // slot lookup with forwarding of the write that overlapped the read
   always_comb begin
      entry    = (fwd_valid_ff && (fwd_idx_ff == s1_idx)) ? fwd_word_ff : rd_word;
      live     = entry.valid && (entry.epoch == epoch_ff);
      key_eq   = (entry.key == s1_fields_ff.key);
      full     = (count_ff >= max_ff);
      is_exact = (s1_fields_ff.bound == BOUND_EXACT);
   end

   always_comb begin
      do_write = 1'b0;
      wipe     = 1'b0;
      grow     = 1'b0;
      hit      = 1'b0;
      priority if (s1_kind_ff == KIND_STORE) begin
         wipe = full;
         if (full || !live) begin
            do_write = 1'b1;
            grow     = 1'b1;
         end else if (!key_eq) begin
            do_write = is_exact && (s1_fields_ff.depth >= entry.depth);
         end else begin
            do_write = (entry.depth < s1_fields_ff.depth) ||
                       (is_exact && (entry.bound != BOUND_EXACT));
         end
      end else if (s1_kind_ff == KIND_PROBE) begin
         hit = live && key_eq;
      end else if (s1_kind_ff == KIND_CLEAR) begin
         wipe = 1'b1;
      end else begin
         wipe = 1'b0;
      end
   end

   assign epoch_in    = wipe ? epoch_ff + 1'b1 : epoch_ff;
   assign count_in    = wipe ? CFG_BITS'(grow) : count_ff + CFG_BITS'(grow);
   assign pipe_wr_en  = s1_advance && do_write;
   assign sweep_start = s1_advance && wipe && (epoch_in[EPOCH_BITS-1] != epoch_ff[EPOCH_BITS-1]);

   always_comb begin
      new_word.valid = 1'b1;
      new_word.epoch = epoch_in;
      new_word.key   = s1_fields_ff.key;
      new_word.move  = move_to_slot(s1_fields_ff.move);
      new_word.score = s1_fields_ff.score;
      new_word.bound = s1_fields_ff.bound;
      new_word.depth = s1_fields_ff.depth;
   end

   always_comb begin
      rsp_data_in         = '0;
      rsp_user_in.hit     = hit;
      rsp_user_in.written = do_write;
      if (hit) begin
         rsp_data_in.move  = move_from_slot(entry.move);
         rsp_data_in.score = entry.score;
         rsp_data_in.bound = entry.bound;
         rsp_data_in.depth = entry.depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         epoch_ff     <= '0;
         count_ff     <= '0;
         max_ff       <= CFG_RESET;
      end else begin
         if (csr_wen) begin
            max_ff <= csr_wdata;
         end
         if (accept) begin
            s1_valid_ff  <= 1'b1;
            fwd_valid_ff <= pipe_wr_en;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
            epoch_ff     <= epoch_in;
            count_ff     <= count_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= req_tuser;
         s1_fields_ff <= req_fields;
         fwd_idx_ff   <= s1_idx;
         fwd_word_ff  <= new_word;
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   ttsp_sweep u_sweep (
      .clock      (clock),
      .reset      (reset),
      .start      (sweep_start),
      .pipe_empty (!s1_valid_ff),
      .epoch      (epoch_ff),
      .rd_word    (rd_word),
      .busy       (sweep_busy),
      .mem_req    (sweep_req)
   );

   always_comb begin
      ram_wr_en   = sweep_req.wr_en || pipe_wr_en;
      ram_wr_addr = sweep_req.wr_en ? sweep_req.wr_addr : s1_idx;
      ram_wr_word = sweep_req.wr_en ? sweep_req.wr_word : new_word;
      ram_rd_en   = sweep_req.rd_en || accept;
      ram_rd_addr = sweep_req.rd_en ? sweep_req.rd_addr : req_fields.key[INDEX_BITS-1:0];
   end

   assign rd_word = slot_type'(ram_rd_data);

   ttsp_ram #(
      .WIDTH     (SLOT_BITS),
      .ADDR_BITS (INDEX_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

/* rtl/core/ttsp_ram.sv */
// simple dual-port synchronous ram with registered read data
module ttsp_ram #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [2**ADDR_BITS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ttsp_sweep.sv */
// sweep sequencer: clears the table after reset and retires stale epochs
module ttsp_sweep
   import ttsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  pipe_empty,
   input  logic [EPOCH_BITS-1:0] epoch,
   input  slot_type              rd_word,
   output logic                  busy,
   output mem_req_type           mem_req
);

   typedef enum logic [1:0] {
      SW_IDLE,
      SW_CLEAR,
      SW_SCAN,
      SW_DRAIN
   } state_type;

   state_type             state_ff;
   logic                  pending_ff;
   logic [INDEX_BITS-1:0] addr_ff;
   logic                  wb_valid_ff;
   logic [INDEX_BITS-1:0] wb_addr_ff;
   logic                  last_addr;
   slot_type              kept_word;

   assign last_addr = &addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SW_CLEAR;
         pending_ff  <= 1'b0;
         addr_ff     <= '0;
         wb_valid_ff <= 1'b0;
         wb_addr_ff  <= '0;
      end else begin
         if (start) begin
            pending_ff <= 1'b1;
         end
         unique case (state_ff)
            SW_IDLE: begin
               wb_valid_ff <= 1'b0;
               if (pending_ff && pipe_empty) begin
                  pending_ff <= 1'b0;
                  addr_ff    <= '0;
                  state_ff   <= SW_SCAN;
               end
            end
            SW_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (last_addr) begin
                  state_ff <= SW_IDLE;
               end
            end
            SW_SCAN: begin
               addr_ff     <= addr_ff + 1'b1;
               wb_valid_ff <= 1'b1;
               wb_addr_ff  <= addr_ff;
               if (last_addr) begin
                  state_ff <= SW_DRAIN;
               end
            end
            SW_DRAIN: begin
               wb_valid_ff <= 1'b0;
               state_ff    <= SW_IDLE;
            end
            default: begin
               state_ff <= SW_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      kept_word       = rd_word;
      kept_word.valid = rd_word.valid && (rd_word.epoch == epoch);
   end

   assign busy = pending_ff || (state_ff != SW_IDLE);

   always_comb begin
      mem_req.rd_en   = (state_ff == SW_SCAN);
      mem_req.rd_addr = addr_ff;
      mem_req.wr_en   = (state_ff == SW_CLEAR) || wb_valid_ff;
      mem_req.wr_addr = (state_ff == SW_CLEAR) ? addr_ff : wb_addr_ff;
      mem_req.wr_word = (state_ff == SW_CLEAR) ? slot_type'('0) : kept_word;
   end

endmodule

/* rtl/core/ttsp_checker.sv */
// port-level checker for the transposition table, bound to the top level
`include "transposition_table_store_probe_top_macros.svh"

module ttsp_checker
   import ttsp_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [RSP_USER_BITS-1:0] rsp_tuser
);

   `TTSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `TTSP_ASSERT_IMPL(a_hit_or_written, clock, reset, rsp_tvalid, !(rsp_tuser[RSP_HIT_BIT] && rsp_tuser[RSP_WRITTEN_BIT]), "hit and written both set")
   `TTSP_ASSERT_IMPL(a_miss_is_zero, clock, reset, rsp_tvalid && !rsp_tuser[RSP_HIT_BIT], rsp_tdata == '0, "entry fields nonzero without a hit")
   `TTSP_ASSERT_IMPL(a_clear_after_reset, clock, reset, $past(reset), !req_tready, "request taken before the clearing pass")
   `TTSP_ASSERT_IMPL(a_rsp_from_req, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "result without a request")

endmodule

bind transposition_table_store_probe_top ttsp_checker u_ttsp_checker (.*);
